### sv/miss_status_holding_table_unit_macros.svh
// Assertion macros for the miss status holding table RTL.
`ifndef MISS_STATUS_HOLDING_TABLE_UNIT_MACROS_SVH
`define MISS_STATUS_HOLDING_TABLE_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define MST_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a consequent holds whenever the antecedent holds.
`define MST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/mst_pkg.sv
// Shared constants, codes and types of the miss status holding table.
`default_nettype none

package mst_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int MERGE_DEPTH   = 8;
  localparam int ADDRESS_BITS  = 40;
  localparam int REQUEST_BITS  = 10;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HEAD_W  = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
  localparam int SUM_W   = HEAD_W + 1;
  localparam int CNT_W   = $clog2(MERGE_DEPTH + 1);
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int MEM_DEPTH = TABLE_ENTRIES * MERGE_DEPTH;
  localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int CFG_ENT_W  = 6;
  localparam int CFG_MRG_W  = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int LIM_E_W = (USED_W > CFG_ENT_W) ? USED_W : CFG_ENT_W;
  localparam int LIM_M_W = (CNT_W > CFG_MRG_W) ? CNT_W : CFG_MRG_W;

  localparam logic [CFG_ENT_W-1:0] ENTRIES_RESET = CFG_ENT_W'(32);
  localparam logic [CFG_MRG_W-1:0] MERGED_RESET  = CFG_MRG_W'(8);

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MERGED     = 2'd1;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_ADD   = 2'd1,
    OP_NEXT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_ENTRY = 2'd2
  } status_e;

  // Registered result of the address match.
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } lookup_t;

  // Slot allocation that writes a new tag.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } alloc_t;

endpackage

`default_nettype wire

### sv/mst_lookup.sv
// Tag store of the miss status holding table with parallel match and free-slot search.
`default_nettype none

module mst_lookup (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                look_en_i,
  input  wire logic [mst_pkg::ADDRESS_BITS-1:0]    addr_i,
  input  wire logic [mst_pkg::TABLE_ENTRIES-1:0]   valid_i,
  input  wire mst_pkg::alloc_t                     alloc_i,
  output mst_pkg::lookup_t                         result_o
);

  logic [mst_pkg::ADDRESS_BITS-1:0] tag_q [mst_pkg::TABLE_ENTRIES];
  mst_pkg::lookup_t                 res_d;
  mst_pkg::lookup_t                 res_q;

  // Scan from the top down so the lowest index wins.
  always_comb begin
    res_d = '0;
    for (int i = mst_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (tag_q[i] == addr_i)) begin
        res_d.hit     = 1'b1;
        res_d.hit_idx = mst_pkg::IDX_W'(i);
      end
      if (!valid_i[i]) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = mst_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i.en) begin
      tag_q[alloc_i.idx] <= addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (look_en_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

### sv/miss_status_holding_table_unit.sv
// Miss status holding table: the tag match registers in S_LOOK, the slot update and the
// read of the merged-request memory both happen in S_EXEC, and S_RESP loads the result
// register once the previous result has been taken. No new request is taken until then.
// Reset clears all slot valid bits, counts, heads, atomic flags and the use count,
// and sets entries_in_use to 32 and max_merged to 8. No clearing pass is needed.
`default_nettype none

module miss_status_holding_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,   // [39:0] block_address, [49:40] request_id, pad
  input  wire logic [2:0]  s_axis_tuser_i,   // [1:0] op, [2] request_atomic
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [0] entry_hit, [1] table_full,
                                             // [11:2] popped_id, [12] entry_released,
                                             // [13] entry_atomic, pad
  output logic [1:0]       m_axis_tuser_o    // [1:0] status
);

`include "miss_status_holding_table_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Captured request.
  logic [1:0]                        op_q;
  logic [mst_pkg::ADDRESS_BITS-1:0]  addr_q;
  logic [mst_pkg::REQUEST_BITS-1:0]  rid_q;
  logic                              atom_q;

  // Configuration registers.
  logic [mst_pkg::CFG_ENT_W-1:0] cfg_ent_q;
  logic [mst_pkg::CFG_MRG_W-1:0] cfg_mrg_q;
  logic [mst_pkg::LIM_E_W-1:0]   lim_ent;
  logic [mst_pkg::LIM_M_W-1:0]   lim_mrg;

  // Per-slot control state.
  logic [mst_pkg::TABLE_ENTRIES-1:0] slot_valid_q;
  logic [mst_pkg::CNT_W-1:0]         slot_count_q  [mst_pkg::TABLE_ENTRIES];
  logic [mst_pkg::HEAD_W-1:0]        slot_head_q   [mst_pkg::TABLE_ENTRIES];
  logic [mst_pkg::TABLE_ENTRIES-1:0] slot_atomic_q;
  logic [mst_pkg::USED_W-1:0]        slots_used_q, slots_used_d;

  // Merged-request memory.
  logic [mst_pkg::REQUEST_BITS-1:0] req_mem [mst_pkg::MEM_DEPTH];
  logic [mst_pkg::REQUEST_BITS-1:0] mem_rdata_q;
  logic                             mem_we, mem_re;
  logic [mst_pkg::MEM_AW-1:0]       mem_addr;

  mst_pkg::lookup_t lk;
  mst_pkg::alloc_t  alloc;

  // Update cycle values.
  logic [mst_pkg::IDX_W-1:0]  idx;
  logic [mst_pkg::CNT_W-1:0]  cnt_b, base_cnt, cnt_n;
  logic [mst_pkg::HEAD_W-1:0] head_b, base_head, head_n, pos;
  logic                       atom_b, base_atom, atom_n, valid_n;
  logic                       upd, full, released, atom_out, pop;
  logic [1:0]                 status;

  // Held result between the update cycle and the response cycle.
  logic [1:0] res_status_q;
  logic       res_hit_q, res_full_q, res_rel_q, res_atom_q, res_pop_q;

  // Output register.
  logic                             out_valid_q;
  logic [1:0]                       out_status_q;
  logic                             out_hit_q, out_full_q, out_rel_q, out_atom_q;
  logic [mst_pkg::REQUEST_BITS-1:0] out_pop_q;
  logic                             out_load;

  function automatic logic [mst_pkg::HEAD_W-1:0] wrap_pos(
    input logic [mst_pkg::SUM_W-1:0] v
  );
    logic [mst_pkg::SUM_W-1:0] r;
    r = v;
    if (v >= mst_pkg::SUM_W'(mst_pkg::MERGE_DEPTH)) begin
      r = v - mst_pkg::SUM_W'(mst_pkg::MERGE_DEPTH);
    end
    return r[mst_pkg::HEAD_W-1:0];
  endfunction

  function automatic logic [mst_pkg::MEM_AW-1:0] mem_index(
    input logic [mst_pkg::IDX_W-1:0]  slot,
    input logic [mst_pkg::HEAD_W-1:0] p
  );
    return mst_pkg::MEM_AW'(slot) * mst_pkg::MEM_AW'(mst_pkg::MERGE_DEPTH)
           + mst_pkg::MEM_AW'(p);
  endfunction

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Clamp the limits to what the table can actually hold.
  assign lim_ent = (mst_pkg::LIM_E_W'(cfg_ent_q) > mst_pkg::LIM_E_W'(mst_pkg::TABLE_ENTRIES))
                   ? mst_pkg::LIM_E_W'(mst_pkg::TABLE_ENTRIES)
                   : mst_pkg::LIM_E_W'(cfg_ent_q);
  assign lim_mrg = (mst_pkg::LIM_M_W'(cfg_mrg_q) > mst_pkg::LIM_M_W'(mst_pkg::MERGE_DEPTH))
                   ? mst_pkg::LIM_M_W'(mst_pkg::MERGE_DEPTH)
                   : mst_pkg::LIM_M_W'(cfg_mrg_q);

  mst_lookup u_lookup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .look_en_i (state_q == S_LOOK),
    .addr_i    (addr_q),
    .valid_i   (slot_valid_q),
    .alloc_i   (alloc),
    .result_o  (lk)
  );

  // Read-modify-write of the matched or freshly allocated slot.
  always_comb begin
    idx       = lk.hit ? lk.hit_idx : lk.free_idx;
    cnt_b     = slot_count_q[idx];
    head_b    = slot_head_q[idx];
    atom_b    = slot_atomic_q[idx];
    full      = lk.hit ? (mst_pkg::LIM_M_W'(cnt_b) >= lim_mrg)
                       : (mst_pkg::LIM_E_W'(slots_used_q) >= lim_ent);
    base_cnt  = lk.hit ? cnt_b : '0;
    base_head = lk.hit ? head_b : '0;
    base_atom = lk.hit & atom_b;
    pos       = wrap_pos(mst_pkg::SUM_W'(base_head) + mst_pkg::SUM_W'(base_cnt));
    status    = mst_pkg::ST_DONE;
    upd       = 1'b0;
    valid_n   = slot_valid_q[idx];
    cnt_n     = cnt_b;
    head_n    = head_b;
    atom_n    = atom_b;
    released  = 1'b0;
    atom_out  = lk.hit & atom_b;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = mem_index(idx, pos);
    alloc.en  = 1'b0;
    alloc.idx = lk.free_idx;
    slots_used_d = slots_used_q;
    case (op_q)
      mst_pkg::OP_ADD: begin
        if (full || (!lk.hit && !lk.free_found)) begin
          status = mst_pkg::ST_FULL;
        end else begin
          mem_we   = 1'b1;
          upd      = 1'b1;
          valid_n  = 1'b1;
          cnt_n    = base_cnt + mst_pkg::CNT_W'(1);
          head_n   = base_head;
          atom_n   = base_atom | atom_q;
          atom_out = base_atom | atom_q;
          if (!lk.hit) begin
            alloc.en     = 1'b1;
            slots_used_d = slots_used_q + mst_pkg::USED_W'(1);
          end
        end
      end
      mst_pkg::OP_NEXT: begin
        if (!lk.hit) begin
          status   = mst_pkg::ST_NO_ENTRY;
          atom_out = 1'b0;
        end else begin
          mem_re   = 1'b1;
          mem_addr = mem_index(idx, head_b);
          pop      = 1'b1;
          upd      = 1'b1;
          atom_out = atom_b;
          cnt_n    = cnt_b - mst_pkg::CNT_W'(1);
          head_n   = wrap_pos(mst_pkg::SUM_W'(head_b) + mst_pkg::SUM_W'(1));
          // Last request gone: free the slot.
          if (cnt_b == mst_pkg::CNT_W'(1)) begin
            valid_n      = 1'b0;
            head_n       = '0;
            atom_n       = 1'b0;
            released     = 1'b1;
            slots_used_d = slots_used_q - mst_pkg::USED_W'(1);
          end
        end
      end
      default: begin
        // Query and the unused code change nothing.
      end
    endcase
    if (state_q != S_EXEC) begin
      upd      = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      alloc.en = 1'b0;
    end
  end

  // Load the output register once the previous result has been taken.
  assign out_load = (state_q == S_RESP) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_EXEC;
      S_EXEC: state_d = S_RESP;
      S_RESP: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_ent_q     <= mst_pkg::ENTRIES_RESET;
      cfg_mrg_q     <= mst_pkg::MERGED_RESET;
      slot_valid_q  <= '0;
      slot_atomic_q <= '0;
      slots_used_q  <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < mst_pkg::TABLE_ENTRIES; i++) begin
        slot_count_q[i] <= '0;
        slot_head_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == mst_pkg::CFG_ENTRIES_IN_USE) begin
          cfg_ent_q <= cfg_data_i[mst_pkg::CFG_ENT_W-1:0];
        end else if (cfg_index_i == mst_pkg::CFG_MAX_MERGED) begin
          cfg_mrg_q <= cfg_data_i[mst_pkg::CFG_MRG_W-1:0];
        end
      end
      if (upd) begin
        slot_valid_q[idx]  <= valid_n;
        slot_count_q[idx]  <= cnt_n;
        slot_head_q[idx]   <= head_n;
        slot_atomic_q[idx] <= atom_n;
        slots_used_q       <= slots_used_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, held results and output payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q   <= s_axis_tuser_i[1:0];
      atom_q <= s_axis_tuser_i[2];
      addr_q <= s_axis_tdata_i[39:0];
      rid_q  <= s_axis_tdata_i[49:40];
    end
    if (state_q == S_EXEC) begin
      res_status_q <= status;
      res_hit_q    <= lk.hit;
      res_full_q   <= full;
      res_rel_q    <= released;
      res_atom_q   <= atom_out;
      res_pop_q    <= pop;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_full_q   <= res_full_q;
      out_rel_q    <= res_rel_q;
      out_atom_q   <= res_atom_q;
      out_pop_q    <= res_pop_q ? mem_rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      req_mem[mem_addr] <= rid_q;
    end
    if (mem_re) begin
      mem_rdata_q <= req_mem[mem_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {2'b00, out_atom_q, out_rel_q, out_pop_q, out_full_q, out_hit_q};

  `MST_ASSERT_ALWAYS(a_used_matches_valid,
    slots_used_q == $countones(slot_valid_q), "use count out of step with valid bits")
  `MST_ASSERT_IMPL(a_hit_has_requests, (state_q == S_EXEC) && lk.hit,
    cnt_b != '0, "valid slot with empty request queue")
  `MST_ASSERT_IMPL(a_release_needs_hit, out_valid_q && out_rel_q,
    out_hit_q && (out_status_q == mst_pkg::ST_DONE), "slot released without a hit")
  `MST_ASSERT_IMPL(a_refuse_when_full, out_valid_q && (out_status_q == mst_pkg::ST_FULL),
    out_full_q, "add refused while not full")

endmodule

`default_nettype wire

### tb/sv/mst_result_checker.sv
// Checker that predicts and compares every result of the miss status holding table.
module mst_result_checker
  import mst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [55:0] req_data_i,    // [39:0] block_address, [49:40] request_id, pad
  input  logic [2:0]  req_user_i,    // [1:0] op, [2] request_atomic
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [15:0] rsp_data_i,    // [0] entry_hit, [1] table_full, [11:2] popped_id,
                                     // [12] entry_released, [13] entry_atomic, pad
  input  logic [1:0]  rsp_user_i,    // [1:0] status
  output int          failures_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e                 status;
    logic                    hit;
    logic                    full;
    logic [REQUEST_BITS-1:0] popped;
    logic                    released;
    logic                    atomic;
  } lookup_result_t;

  // Shadow copy of the table and its two registers.
  logic                    slot_on   [TABLE_ENTRIES];
  logic [ADDRESS_BITS-1:0] slot_tag  [TABLE_ENTRIES];
  int                      slot_cnt  [TABLE_ENTRIES];
  int                      slot_head [TABLE_ENTRIES];
  logic                    slot_atom [TABLE_ENTRIES];
  logic [REQUEST_BITS-1:0] merged_ids[TABLE_ENTRIES][MERGE_DEPTH];
  int                      slots_taken;
  logic [CFG_ENT_W-1:0]    entries_reg;
  logic [CFG_MRG_W-1:0]    merged_reg;

  lookup_result_t pending_results[$];
  lookup_result_t seen;
  lookup_result_t due;
  int             failures;

  // Apply one request to the shadow table and return the result it must produce.
  function automatic lookup_result_t resolve_request(logic [1:0] op,
                                                     logic [ADDRESS_BITS-1:0] addr,
                                                     logic [REQUEST_BITS-1:0] rid,
                                                     logic atom);
    lookup_result_t r;
    int s;
    int lim_e;
    int lim_m;
    lim_e = (entries_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entries_reg);
    lim_m = (merged_reg > MERGE_DEPTH) ? MERGE_DEPTH : int'(merged_reg);
    s = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (s < 0 && slot_on[i] && slot_tag[i] == addr) s = i;
    r = '0;
    r.status = ST_DONE;
    r.hit = (s >= 0);
    r.full = r.hit ? (slot_cnt[s] >= lim_m) : (slots_taken >= lim_e);
    if (op == OP_ADD) begin
      if (r.full) begin
        r.status = ST_FULL;
      end else begin
        if (s < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (s < 0 && !slot_on[i]) s = i;
          if (s >= 0) begin
            slot_on[s]   = 1'b1;
            slot_tag[s]  = addr;
            slot_cnt[s]  = 0;
            slot_head[s] = 0;
            slot_atom[s] = 1'b0;
            slots_taken++;
          end
        end
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          merged_ids[s][(slot_head[s] + slot_cnt[s]) % MERGE_DEPTH] = rid;
          slot_cnt[s]++;
          if (atom) slot_atom[s] = 1'b1;
        end
      end
    end else if (op == OP_NEXT) begin
      if (s < 0) begin
        r.status = ST_NO_ENTRY;
      end else begin
        r.popped = merged_ids[s][slot_head[s]];
        slot_head[s] = (slot_head[s] + 1) % MERGE_DEPTH;
        if (slot_cnt[s] > 0) slot_cnt[s]--;
        // the flag of the popped entry is reported even when it is freed
        r.atomic = slot_atom[s];
        if (slot_cnt[s] == 0) begin
          slot_on[s]   = 1'b0;
          slot_head[s] = 0;
          slot_atom[s] = 1'b0;
          if (slots_taken > 0) slots_taken--;
          r.released = 1'b1;
        end
      end
    end
    if (op != OP_NEXT && s >= 0 && slot_on[s]) r.atomic = slot_atom[s];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_on[i]   = 1'b0;
        slot_cnt[i]  = 0;
        slot_head[i] = 0;
        slot_atom[i] = 1'b0;
      end
      slots_taken = 0;
      entries_reg = ENTRIES_RESET;
      merged_reg  = MERGED_RESET;
      pending_results.delete();
      failures = 0;
      failures_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ENTRIES_IN_USE) entries_reg = cfg_data_i[CFG_ENT_W-1:0];
        else if (cfg_index_i == CFG_MAX_MERGED) merged_reg = cfg_data_i[CFG_MRG_W-1:0];
      end
      // Retire a result before adding the one for a request taken at the same edge.
      if (rsp_valid_i && rsp_ready_i) begin
        seen.status   = status_e'(rsp_user_i);
        seen.hit      = rsp_data_i[0];
        seen.full     = rsp_data_i[1];
        seen.popped   = rsp_data_i[11:2];
        seen.released = rsp_data_i[12];
        seen.atomic   = rsp_data_i[13];
        if (pending_results.size() == 0) begin
          if (failures < 10)
            $display("%0t: result with no request waiting: status=%0d hit=%0b full=%0b",
                     $realtime, seen.status, seen.hit, seen.full);
          failures++;
        end else begin
          due = pending_results[0];
          pending_results.delete(0);
          if (seen.status !== due.status || seen.hit !== due.hit || seen.full !== due.full ||
              seen.popped !== due.popped || seen.released !== due.released ||
              seen.atomic !== due.atomic) begin
            if (failures < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d hit=%0b full=%0b id=%0d released=%0b atomic=%0b",
                       due.status, due.hit, due.full, due.popped, due.released, due.atomic);
              $display("  actual   status=%0d hit=%0b full=%0b id=%0d released=%0b atomic=%0b",
                       seen.status, seen.hit, seen.full, seen.popped, seen.released,
                       seen.atomic);
            end
            failures++;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        pending_results.insert(pending_results.size(),
                               resolve_request(req_user_i[1:0], req_data_i[39:0],
                                               req_data_i[49:40], req_user_i[2]));
      failures_o <= failures;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

### tb/sv/miss_status_holding_table_unit_tb.sv
// Stimulus, clock, reset and verdict for the miss status holding table testbench.
module miss_status_holding_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mst_pkg::*;

  // Op code outside the enum: the block must treat it as a plain query.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Register index with no register behind it: the write must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Leave margin after the last result before touching registers.
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;    // [39:0] block_address, [49:40] request_id, pad
  logic [2:0]  s_axis_tuser = '0;    // [1:0] op, [2] request_atomic
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] entry_hit, [1] table_full, [11:2] popped_id,
                                     // [12] entry_released, [13] entry_atomic, pad
  logic [1:0]  m_axis_tuser;         // [1:0] status

  int   failures;
  int   outstanding;
  int   quiet_cycles = 0;
  int   rx_hold = 0;
  logic rx_steady = 1'b0;
  logic tx_steady = 1'b0;

  always #2 clk_i = ~clk_i;

  miss_status_holding_table_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  mst_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_user_i    (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .rsp_user_i    (m_axis_tuser),
    .failures_o    (failures),
    .outstanding_o (outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [ADDRESS_BITS-1:0] random_address();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[ADDRESS_BITS-1:0];
  endfunction

  // Stall the result side at random; hold tready high through steady stretches.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  // Restart the count on any handshake; give up after a long silent stretch.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one request at the falling edge and hold it until it is taken.
  task automatic push_request(logic [1:0] op, logic [ADDRESS_BITS-1:0] addr,
                              logic [REQUEST_BITS-1:0] rid, logic atom);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, rid, addr};
    s_axis_tuser  <= {atom, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_for(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drop valid and hold off until every result has come back, then let the pipe settle.
  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [5:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic over a pool of addresses, so entries fill, merge, drain and wrap.
  // A few fresh addresses add misses; one drain in the middle empties the pipe.
  task automatic issue_requests(int count, int pool_size);
    logic [ADDRESS_BITS-1:0] pool [64];
    logic [ADDRESS_BITS-1:0] addr;
    logic [1:0]              op;
    int                      r;
    for (int i = 0; i < pool_size; i++) pool[i] = random_address();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 48)      op = OP_ADD;
      else if (r < 88) op = OP_NEXT;
      else if (r < 96) op = OP_QUERY;
      else             op = OP_SPARE;
      if ($urandom_range(0, 9) == 0) addr = random_address();
      else addr = pool[$urandom_range(0, pool_size - 1)];
      if (!tx_steady && $urandom_range(0, 2) == 0) idle_for(pick_gap());
      push_request(op, addr, REQUEST_BITS'($urandom()), ($urandom_range(0, 4) == 0));
      if (k == count / 2) hold_until_drained();
    end
  endtask

  // Retune both registers once the block is idle, then run traffic.
  task automatic run_phase(logic [5:0] entries, logic [5:0] merged, int pool_size,
                           int count, logic steady);
    hold_until_drained();
    write_register(CFG_ENTRIES_IN_USE, entries);
    write_register(CFG_MAX_MERGED, merged);
    tx_steady = steady;
    rx_steady = steady;
    issue_requests(count, pool_size);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset settings: all-zero and all-ones addresses and ids,
    // every op, the spare op, merge up to the limit, refuse when full,
    // pop to release, and next on a missing entry.
    tx_steady = 1'b1;
    push_request(OP_QUERY, '0, '0, 1'b0);
    push_request(OP_NEXT, '0, '0, 1'b0);
    push_request(OP_SPARE, '1, '1, 1'b1);
    push_request(OP_ADD, '0, '0, 1'b0);
    push_request(OP_ADD, '1, '1, 1'b1);
    for (int i = 1; i < MERGE_DEPTH; i++)
      push_request(OP_ADD, '0, REQUEST_BITS'(i), (i == 4));
    push_request(OP_ADD, '0, REQUEST_BITS'(MERGE_DEPTH), 1'b0);
    push_request(OP_QUERY, '0, '0, 1'b0);
    push_request(OP_NEXT, '1, '0, 1'b0);
    for (int i = 0; i < MERGE_DEPTH; i++)
      push_request(OP_NEXT, '0, '0, 1'b0);
    push_request(OP_NEXT, '0, '0, 1'b0);

    // Write the index with no register behind it once; nothing may change.
    hold_until_drained();
    write_register(CFG_UNUSED, 6'h2A);

    run_phase(6'd32, 6'd8, 40, 250, 1'b0);    // full table, more addresses than entries
    run_phase(6'd1, 6'd1, 4, 120, 1'b0);      // lowest in-range settings
    run_phase(6'd0, 6'h30, 6, 60, 1'b0);      // zero registers, upper data bits ignored
    run_phase(6'h3F, 6'h3F, 48, 250, 1'b0);   // above range, capped by the table size
    run_phase(6'd2, 6'd3, 6, 150, 1'b1);      // lowered below use, no idling at all
    repeat (2)
      run_phase(6'($urandom_range(1, 32)), 6'($urandom_range(1, 8)),
                $urandom_range(2, 40), 200, 1'b0);

    hold_until_drained();
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
